FILE: rtl/vrt_pkg.sv
// Shared types and constants for the voxel ray traversal block.
package vrt_pkg;

	localparam int GRID_SIDE_DEF = 32;
	localparam int FRAC_BITS     = 16;
	localparam int RES_W         = 49;   // widest result of the iterative unit (32x17 product)
	localparam int TW            = 34;   // crossing time width
	localparam int DW            = 33;   // per-voxel time step width

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_CAST  = 1'b1;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIV,
		OP_SQRT
	} iter_op_t;

	// a: MUL a[31:0], DIV dividend a[32:0], SQRT radicand a[63:0]
	// b: MUL b[16:0], DIV divisor b[15:0]
	typedef struct packed {
		logic       start;
		iter_op_t   op;
		logic [63:0] a;
		logic [31:0] b;
	} iter_req_t;

	typedef struct packed {
		logic we;
		logic wdata;
		logic re;
	} mem_req_t;

endpackage

FILE: rtl/vrt_iter_unit.sv
// Shared multiply / bit-serial divide / digit-serial square root unit.
module vrt_iter_unit import vrt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  iter_req_t        req,
	output logic             done,
	output logic [RES_W-1:0] res
);

	logic             busy_q;
	logic             done_q;
	iter_op_t         op_q;
	logic [5:0]       cnt_q;
	logic [63:0]      x_q;
	logic [35:0]      rem_q;
	logic [32:0]      quo_q;
	logic [15:0]      dvs_q;
	logic [RES_W-1:0] res_q;

	logic [35:0] div_r;
	logic [35:0] sq_r;
	logic [35:0] sq_trial;

	assign div_r    = {rem_q[34:0], x_q[63]};
	assign sq_r     = {rem_q[33:0], x_q[63:62]};
	assign sq_trial = {2'b00, quo_q[31:0], 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_MUL;
			cnt_q  <= '0;
		end else begin
			if (req.start) begin
				op_q <= req.op;
				case (req.op)
					OP_MUL: begin
						done_q <= 1'b1;
					end
					OP_DIV: begin
						busy_q <= 1'b1;
						done_q <= 1'b0;
						cnt_q  <= 6'd33;
					end
					OP_SQRT: begin
						busy_q <= 1'b1;
						done_q <= 1'b0;
						cnt_q  <= 6'd32;
					end
					default: begin
						done_q <= 1'b1;
					end
				endcase
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					done_q <= 1'b0;
					cnt_q  <= cnt_q - 6'd1;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= '0;
			dvs_q <= req.b[15:0];
			case (req.op)
				OP_MUL: begin
					res_q <= RES_W'(req.a[31:0]) * RES_W'(req.b[16:0]);
					x_q   <= req.a;
				end
				OP_DIV: begin
					x_q <= {req.a[32:0], 31'b0};
				end
				default: begin
					x_q <= req.a;
				end
			endcase
		end else if (busy_q) begin
			if (cnt_q == 6'd0) begin
				res_q <= RES_W'(quo_q);
			end else if (op_q == OP_DIV) begin
				x_q <= {x_q[62:0], 1'b0};
				if (div_r >= 36'(dvs_q)) begin
					rem_q <= div_r - 36'(dvs_q);
					quo_q <= {quo_q[31:0], 1'b1};
				end else begin
					rem_q <= div_r;
					quo_q <= {quo_q[31:0], 1'b0};
				end
			end else begin
				x_q <= {x_q[61:0], 2'b00};
				if (sq_r >= sq_trial) begin
					rem_q <= sq_r - sq_trial;
					quo_q <= {quo_q[31:0], 1'b1};
				end else begin
					rem_q <= sq_r;
					quo_q <= {quo_q[31:0], 1'b0};
				end
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

FILE: rtl/vrt_occ_mem.sv
// Occupancy bitmap: one bit per voxel, cleared by a sweep after reset.
module vrt_occ_mem import vrt_pkg::*; #(
	parameter int GRID_SIDE = GRID_SIDE_DEF,
	localparam int DEPTH = GRID_SIDE * GRID_SIDE * GRID_SIDE,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  mem_req_t      req,
	input  logic [AW-1:0] waddr,
	input  logic [AW-1:0] raddr,
	output logic          rdata,
	output logic          ready
);

	logic          mem [DEPTH];
	logic          clr_busy_q;
	logic [AW-1:0] clr_q;
	logic          rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_q      <= '0;
		end else if (clr_busy_q) begin
			if (clr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_q] <= 1'b0;
		end else if (req.we) begin
			mem[waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
	assign ready = !clr_busy_q;

endmodule

FILE: rtl/voxel_ray_traversal.sv
// Voxel ray caster: occupancy bitmap with a sequenced 3D DDA walk.
// A cast runs setup in the shared iterative unit (three squares, a 32-step square root,
// then per moving axis a multiply and two 33-step divides), then walks the boundary
// crossings, reading the bitmap for each in-grid candidate voxel; one item at a time.
// After reset the bitmap is swept clear with s_tready low.
// Reset is asynchronous, active low; it clears all control state.
module voxel_ray_traversal import vrt_pkg::*; #(
	parameter int GRID_SIDE = GRID_SIDE_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// voxel_x, voxel_y, voxel_z, voxel_solid, origin_x, origin_y, origin_z,
	// dir_x, dir_y, dir_z, reach, one pad bit
	input  logic [151:0] s_tdata,
	input  logic [0:0]   s_tuser,    // cmd
	output logic         m_tvalid,
	input  logic         m_tready,
	// hit_x, hit_y, hit_z, prev_x, prev_y, prev_z, normal_x, normal_y, normal_z,
	// hit_distance, six pad bits
	output logic [95:0]  m_tdata,
	output logic [0:0]   m_tuser     // hit
);

	localparam int DEPTH = GRID_SIDE * GRID_SIDE * GRID_SIDE;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [3:0] {
		S_IDLE, S_ISSUE, S_WAIT, S_START, S_START_CHK, S_MIN, S_RD, S_CHK, S_STEP, S_OUT
	} state_t;

	typedef enum logic [2:0] {
		ST_SQ, ST_SQRT, ST_MULG, ST_DIVG, ST_DIVD
	} step_t;

	function automatic logic in_grid(input logic signed [9:0] c);
		return !c[9] && ($unsigned(c) < 10'(GRID_SIDE));
	endfunction

	function automatic logic [AW-1:0] vox_addr(input logic [9:0] x, input logic [9:0] y,
			input logic [9:0] z);
		return AW'(z) * AW'(GRID_SIDE * GRID_SIDE) + AW'(y) * AW'(GRID_SIDE) + AW'(x);
	endfunction

	// input decode
	logic [4:0]  in_vx, in_vy, in_vz;
	logic        in_solid;
	logic [20:0] in_org [3];
	logic [15:0] in_dir [3];
	logic [23:0] in_reach;
	logic        s_acc;

	assign in_vx     = s_tdata[4:0];
	assign in_vy     = s_tdata[9:5];
	assign in_vz     = s_tdata[14:10];
	assign in_solid  = s_tdata[15];
	assign in_org[0] = s_tdata[36:16];
	assign in_org[1] = s_tdata[57:37];
	assign in_org[2] = s_tdata[78:58];
	assign in_dir[0] = s_tdata[94:79];
	assign in_dir[1] = s_tdata[110:95];
	assign in_dir[2] = s_tdata[126:111];
	assign in_reach  = s_tdata[150:127];

	state_t             state_q;
	step_t              step_q;
	logic [1:0]         axis_q;
	logic [15:0]        org_frac_q [3];
	logic [15:0]        mag_q [3];
	logic [2:0]         pos_q;
	logic [23:0]        reach_q;
	logic [31:0]        lensq_q;
	logic [31:0]        len_q;
	logic [32:0]        prod_q;
	logic [TW-1:0]      tmax_q [3];
	logic [DW-1:0]      tdel_q [3];
	logic signed [9:0]  blk_q [3];
	logic signed [9:0]  cand_q [3];
	logic [2:0]         mask_q, full_q;
	logic               first_q;
	logic [TW-1:0]      next_q;
	logic               ingrid_q;

	logic               hit_q;
	logic [9:0]         hitc_q [3];
	logic [9:0]         prev_q [3];
	logic [1:0]         nrm_q [3];
	logic [23:0]        dist_q;

	iter_req_t          ireq;
	logic               idone;
	logic [RES_W-1:0]   ires;
	mem_req_t           mreq;
	logic [AW-1:0]      waddr, raddr;
	logic               mrdata, mready;

	logic [2:0]         moves;
	logic [16:0]        gap;
	logic               skip_axis;
	logic               have;
	logic [TW-1:0]      nxt;
	logic [2:0]         full_c;
	logic signed [9:0]  cand [3];
	logic               cand_in;
	logic               elig;
	logic [31:0]        sq_sum;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			moves[i] = mag_q[i] != 16'd0;
		end
	end

	assign gap = pos_q[axis_q] ? 17'h10000 - 17'(org_frac_q[axis_q])
				: 17'(org_frac_q[axis_q]);
	assign skip_axis = (step_q == ST_MULG) && !moves[axis_q];
	assign sq_sum = lensq_q + ires[31:0];

	always_comb begin
		have = 1'b0;
		nxt  = '0;
		for (int i = 0; i < 3; i++) begin
			if (moves[i] && (!have || tmax_q[i] < nxt)) begin
				nxt  = tmax_q[i];
				have = 1'b1;
			end
		end
		for (int i = 0; i < 3; i++) begin
			full_c[i] = moves[i] && ((tmax_q[i] - nxt) <= TW'(1));
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cand[i] = blk_q[i] + (mask_q[i] ? (pos_q[i] ? 10'sd1 : -10'sd1) : 10'sd0);
		end
		cand_in = in_grid(cand[0]) && in_grid(cand[1]) && in_grid(cand[2]);
		elig = first_q || ((mask_q != full_q) && ((mask_q & full_q) == mask_q));
	end

	// shared unit requests
	always_comb begin
		ireq.start = (state_q == S_ISSUE) && !skip_axis;
		ireq.op    = OP_MUL;
		ireq.a     = '0;
		ireq.b     = '0;
		case (step_q)
			ST_SQ: begin
				ireq.a = 64'(mag_q[axis_q]);
				ireq.b = 32'(mag_q[axis_q]);
			end
			ST_SQRT: begin
				ireq.op = OP_SQRT;
				ireq.a  = {lensq_q, 32'b0};
			end
			ST_MULG: begin
				ireq.a = 64'(len_q);
				ireq.b = 32'(gap);
			end
			ST_DIVG: begin
				ireq.op = OP_DIV;
				ireq.a  = 64'(prod_q);
				ireq.b  = 32'(mag_q[axis_q]);
			end
			ST_DIVD: begin
				ireq.op = OP_DIV;
				ireq.a  = 64'(len_q);
				ireq.b  = 32'(mag_q[axis_q]);
			end
			default: begin
				ireq.op = OP_MUL;
			end
		endcase
	end

	assign s_tready = (state_q == S_IDLE) && mready;
	assign s_acc    = s_tvalid && s_tready;

	assign mreq.we    = s_acc && (s_tuser[0] == CMD_WRITE)
				&& in_grid(10'(in_vx)) && in_grid(10'(in_vy)) && in_grid(10'(in_vz));
	assign mreq.wdata = in_solid;
	assign mreq.re    = ((state_q == S_START)
				&& in_grid(blk_q[0]) && in_grid(blk_q[1]) && in_grid(blk_q[2]))
				|| ((state_q == S_RD) && elig && cand_in);
	assign waddr = vox_addr(10'(in_vx), 10'(in_vy), 10'(in_vz));
	assign raddr = (state_q == S_START)
				? vox_addr(blk_q[0], blk_q[1], blk_q[2])
				: vox_addr(cand[0], cand[1], cand[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			step_q   <= ST_SQ;
			axis_q   <= '0;
			pos_q    <= '0;
			reach_q  <= '0;
			lensq_q  <= '0;
			len_q    <= '0;
			prod_q   <= '0;
			mask_q   <= '0;
			full_q   <= '0;
			first_q  <= 1'b0;
			next_q   <= '0;
			ingrid_q <= 1'b0;
			hit_q    <= 1'b0;
			dist_q   <= '0;
			for (int i = 0; i < 3; i++) begin
				org_frac_q[i] <= '0;
				mag_q[i]      <= '0;
				tmax_q[i]     <= '0;
				tdel_q[i]     <= '0;
				blk_q[i]      <= '0;
				cand_q[i]     <= '0;
				hitc_q[i]     <= '0;
				prev_q[i]     <= '0;
				nrm_q[i]      <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_acc && (s_tuser[0] == CMD_CAST)) begin
						hit_q   <= 1'b0;
						dist_q  <= '0;
						reach_q <= in_reach;
						lensq_q <= '0;
						step_q  <= ST_SQ;
						axis_q  <= '0;
						for (int i = 0; i < 3; i++) begin
							org_frac_q[i] <= in_org[i][15:0];
							blk_q[i]      <= 10'(in_org[i][20:16]);
							pos_q[i]      <= !in_dir[i][15] && (in_dir[i] != 16'd0);
							mag_q[i]      <= in_dir[i][15] ? 16'(17'h10000 - 17'(in_dir[i]))
										: in_dir[i];
							hitc_q[i]     <= '0;
							prev_q[i]     <= '0;
							nrm_q[i]      <= '0;
						end
						state_q <= (in_reach == 24'd0) ? S_OUT : S_ISSUE;
					end
				end
				S_ISSUE: begin
					if (skip_axis) begin
						tmax_q[axis_q] <= '0;
						tdel_q[axis_q] <= '0;
						if (axis_q == 2'd2) begin
							state_q <= S_START;
						end else begin
							axis_q <= axis_q + 2'd1;
						end
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (idone) begin
						case (step_q)
							ST_SQ: begin
								lensq_q <= sq_sum;
								if (axis_q == 2'd2) begin
									axis_q  <= '0;
									step_q  <= ST_SQRT;
									state_q <= (sq_sum == 32'd0) ? S_OUT : S_ISSUE;
								end else begin
									axis_q  <= axis_q + 2'd1;
									state_q <= S_ISSUE;
								end
							end
							ST_SQRT: begin
								len_q   <= ires[31:0];
								step_q  <= ST_MULG;
								state_q <= S_ISSUE;
							end
							ST_MULG: begin
								prod_q  <= ires[48:16];
								step_q  <= ST_DIVG;
								state_q <= S_ISSUE;
							end
							ST_DIVG: begin
								tmax_q[axis_q] <= TW'(ires[32:0]);
								step_q         <= ST_DIVD;
								state_q        <= S_ISSUE;
							end
							ST_DIVD: begin
								tdel_q[axis_q] <= ires[32:0];
								step_q         <= ST_MULG;
								if (axis_q == 2'd2) begin
									state_q <= S_START;
								end else begin
									axis_q  <= axis_q + 2'd1;
									state_q <= S_ISSUE;
								end
							end
							default: begin
								step_q  <= ST_SQ;
								state_q <= S_ISSUE;
							end
						endcase
					end
				end
				S_START: begin
					ingrid_q <= in_grid(blk_q[0]) && in_grid(blk_q[1]) && in_grid(blk_q[2]);
					state_q  <= S_START_CHK;
				end
				S_START_CHK: begin
					if (ingrid_q && mrdata) begin
						hit_q <= 1'b1;
						for (int i = 0; i < 3; i++) begin
							hitc_q[i] <= blk_q[i];
							prev_q[i] <= blk_q[i];
						end
						state_q <= S_OUT;
					end else begin
						state_q <= S_MIN;
					end
				end
				S_MIN: begin
					if (!have || nxt > TW'(reach_q)) begin
						state_q <= S_OUT;
					end else begin
						next_q  <= nxt;
						full_q  <= full_c;
						mask_q  <= full_c;
						first_q <= 1'b1;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (elig) begin
						for (int i = 0; i < 3; i++) begin
							cand_q[i] <= cand[i];
						end
						ingrid_q <= cand_in;
						state_q  <= S_CHK;
					end else if (mask_q == 3'd7) begin
						state_q <= S_STEP;
					end else begin
						mask_q <= mask_q + 3'd1;
					end
				end
				S_CHK: begin
					if (ingrid_q && mrdata) begin
						hit_q  <= 1'b1;
						dist_q <= (next_q > TW'(24'hFFFFFF)) ? 24'hFFFFFF : next_q[23:0];
						for (int i = 0; i < 3; i++) begin
							hitc_q[i] <= cand_q[i];
							prev_q[i] <= blk_q[i];
							nrm_q[i]  <= mask_q[i] ? (pos_q[i] ? 2'b11 : 2'b01) : 2'b00;
						end
						state_q <= S_OUT;
					end else if (first_q) begin
						// full step missed: now the smaller subsets, lowest mask first
						first_q <= 1'b0;
						mask_q  <= 3'd1;
						state_q <= S_RD;
					end else if (mask_q == 3'd7) begin
						state_q <= S_STEP;
					end else begin
						mask_q  <= mask_q + 3'd1;
						state_q <= S_RD;
					end
				end
				S_STEP: begin
					for (int i = 0; i < 3; i++) begin
						if (full_q[i]) begin
							blk_q[i]  <= blk_q[i] + (pos_q[i] ? 10'sd1 : -10'sd1);
							tmax_q[i] <= tmax_q[i] + TW'(tdel_q[i]);
						end
					end
					state_q <= S_MIN;
				end
				S_OUT: begin
					if (m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	vrt_iter_unit u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ireq),
		.done   (idone),
		.res    (ires)
	);

	vrt_occ_mem #(
		.GRID_SIDE (GRID_SIDE)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.waddr  (waddr),
		.raddr  (raddr),
		.rdata  (mrdata),
		.ready  (mready)
	);

	assign m_tvalid   = (state_q == S_OUT);
	assign m_tuser[0] = hit_q;
	assign m_tdata    = {6'b0, dist_q, nrm_q[2], nrm_q[1], nrm_q[0],
				prev_q[2], prev_q[1], prev_q[0], hitc_q[2], hitc_q[1], hitc_q[0]};

`ifndef SYNTH
	a_no_accept_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input accepted while a result is pending");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == 96'd0))
		else $error("miss result carries nonzero payload");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		!mready |-> !s_tready)
		else $error("item accepted during bitmap clear");
`endif

endmodule
